FILE: rtl/core/pdpr_pkg.sv
package pdpr_pkg;

   localparam int GRID_ROWS   = 8;
   localparam int CSR_INDEX_W = 1;

   localparam logic [2:0] ACT_TICK        = 3'd0;
   localparam logic [2:0] ACT_PAD_EVENT   = 3'd1;
   localparam logic [2:0] ACT_HANDBRAKE   = 3'd2;
   localparam logic [2:0] ACT_RESET_MOTION = 3'd3;
   localparam logic [2:0] ACT_RELEASE_ALL = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SPEED   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_PERIOD = 1'b1;

   localparam logic [3:0]  MAX_SPEED_RESET   = 4'd2;
   localparam logic [31:0] TICK_PERIOD_RESET = 32'd89478;
   localparam logic [31:0] FULL_SPEED        = 32'h8000_0000;

   // ceil(2^33 / 3): x * RECIP_3 >> 33 is floor(x / 3) for any 32-bit x
   localparam logic [31:0] RECIP_3 = 32'hAAAA_AAAB;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
   } mul_op_type;

endpackage

FILE: rtl/core/pdpr_mul.sv
module pdpr_mul (
   input  logic                clock,
   input  pdpr_pkg::mul_op_type op,
   output logic [63:0]         prod
);

   logic [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 64'(op.a) * 64'(op.b);
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/core/pdpr_speed.sv
module pdpr_speed #(
   parameter int PEDAL_LEVELS = 4
) (
   input  logic [31:0]                    speed,
   input  logic [31:0]                    step_base,
   input  logic [pdpr_pkg::GRID_ROWS-1:0] pads,
   output logic [31:0]                    speed_next
);

   localparam int LEVELS = (PEDAL_LEVELS < pdpr_pkg::GRID_ROWS) ?
                           PEDAL_LEVELS : pdpr_pkg::GRID_ROWS;

   logic [31:0] throttle_step;
   logic [31:0] brake_step;
   logic signed [33:0] sum;

   // walk inward to outward so the outermost held pad of each group wins
   always_comb begin
      throttle_step = '0;
      brake_step    = '0;
      for (int r = LEVELS - 1; r >= 0; r--) begin
         if (pads[r]) begin
            throttle_step = step_base >> r;
         end
         if (pads[pdpr_pkg::GRID_ROWS - 1 - r]) begin
            brake_step = step_base >> r;
         end
      end
   end

   always_comb begin
      sum = $signed({2'b00, speed}) + $signed({2'b00, throttle_step})
            - $signed({2'b00, brake_step});
      priority if (sum < 0) begin
         speed_next = '0;
      end else if (sum > $signed({2'b00, pdpr_pkg::FULL_SPEED})) begin
         speed_next = pdpr_pkg::FULL_SPEED;
      end else begin
         speed_next = sum[31:0];
      end
   end

endmodule

FILE: rtl/core/pedal_driven_phase_ramps.sv
// Steps: a tick first derives the step base on the shared multiplier (DIV, SCALE),
// then walks each column through SPEED, MUL and POS (speed, multiply, position);
// each column's result is registered in the output register from POS. A new
// request is not taken until the walk has finished the last column; a stalled result
// holds the walk. Other actions act at the accepting edge, one item per cycle while no tick is in progress. Reset
// (synchronous, active high) zeroes motion, releases pads, loads 2 and 89478.
module pedal_driven_phase_ramps #(
   parameter int NUM_COLUMNS  = 8,
   parameter int PEDAL_LEVELS = 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [2:0]  req_pad_row,
   input  logic [2:0]  req_pad_column,
   input  logic        req_pressed,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_column,
   output logic [31:0] rsp_position,
   output logic [31:0] rsp_speed,
   output logic [2:0]  rsp_cursor_row,
   output logic        rsp_moving,
   output logic        rsp_last,

   input  logic                             csr_write,
   input  logic [pdpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wdata
);

   localparam int CNT_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
   localparam logic [CNT_W-1:0] LAST_COL = CNT_W'(NUM_COLUMNS - 1);

   typedef enum logic [2:0] {
      IDLE,
      DIV,
      SCALE,
      SPEED,
      MUL,
      POS
   } state_type;

   state_type state_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic [3:0]  max_speed_ff;
   logic [31:0] tick_period_ff;
   logic [31:0] step_base_ff;
   logic [31:0] speed_ff [NUM_COLUMNS];
   logic [31:0] position_ff [NUM_COLUMNS];
   logic [pdpr_pkg::GRID_ROWS-1:0][NUM_COLUMNS-1:0] pad_held_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_column_ff;
   logic [31:0] rsp_position_ff;
   logic [31:0] rsp_speed_ff;
   logic        rsp_last_ff;

   pdpr_pkg::mul_op_type mul_op;
   logic [63:0] mul_prod;
   logic [3:0]  eff_max;
   logic [67:0] scaled;
   logic [31:0] pos_in;
   logic [31:0] speed_in;
   logic [pdpr_pkg::GRID_ROWS-1:0] col_pads;
   logic        req_take;
   logic        rsp_free;
   logic        col_ok;
   logic [CNT_W-1:0] req_col;

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign col_ok   = int'(req_pad_column) < NUM_COLUMNS;
   assign req_col  = CNT_W'(req_pad_column);

   always_comb begin
      priority if (max_speed_ff == 4'd0) begin
         eff_max = 4'd1;
      end else if (max_speed_ff > 4'd8) begin
         eff_max = 4'd8;
      end else begin
         eff_max = max_speed_ff;
      end
   end

   always_comb begin
      if (state_ff == DIV) begin
         mul_op.a = {1'b0, tick_period_ff[31:1]};
         mul_op.b = pdpr_pkg::RECIP_3;
      end else begin
         mul_op.a = speed_ff[cnt_ff];
         mul_op.b = tick_period_ff;
      end
   end

   pdpr_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (mul_prod)
   );

   always_comb begin
      for (int r = 0; r < pdpr_pkg::GRID_ROWS; r++) begin
         col_pads[r] = pad_held_ff[r][cnt_ff];
      end
   end

   pdpr_speed #(
      .PEDAL_LEVELS (PEDAL_LEVELS)
   ) u_speed (
      .speed      (speed_ff[cnt_ff]),
      .step_base  (step_base_ff),
      .pads       (col_pads),
      .speed_next (speed_in)
   );

   // floor(S * T * M / 2^31), kept modulo one traversal
   assign scaled = 68'(mul_prod) * 68'(eff_max);
   assign pos_in = position_ff[cnt_ff] + scaled[62:31];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= IDLE;
         cnt_ff         <= '0;
         max_speed_ff   <= pdpr_pkg::MAX_SPEED_RESET;
         tick_period_ff <= pdpr_pkg::TICK_PERIOD_RESET;
         pad_held_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int c = 0; c < NUM_COLUMNS; c++) begin
            speed_ff[c]    <= '0;
            position_ff[c] <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               pdpr_pkg::CSR_MAX_SPEED:   max_speed_ff   <= csr_wdata[3:0];
               pdpr_pkg::CSR_TICK_PERIOD: tick_period_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (state_ff == POS && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            IDLE: begin
               if (req_take) begin
                  unique case (req_action)
                     pdpr_pkg::ACT_TICK: begin
                        cnt_ff   <= '0;
                        state_ff <= DIV;
                     end
                     pdpr_pkg::ACT_PAD_EVENT: begin
                        if (col_ok) begin
                           pad_held_ff[req_pad_row][req_col] <= req_pressed;
                        end
                     end
                     pdpr_pkg::ACT_HANDBRAKE: begin
                        if (col_ok && req_pressed) begin
                           speed_ff[req_col] <= '0;
                        end
                     end
                     pdpr_pkg::ACT_RESET_MOTION: begin
                        for (int c = 0; c < NUM_COLUMNS; c++) begin
                           speed_ff[c]    <= '0;
                           position_ff[c] <= '0;
                        end
                     end
                     pdpr_pkg::ACT_RELEASE_ALL: begin
                        pad_held_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            DIV: begin
               state_ff <= SCALE;
            end
            SCALE: begin
               // floor(T / 6) = floor(floor(T / 2) / 3)
               step_base_ff <= {1'b0, mul_prod[63:33]};
               state_ff     <= SPEED;
            end
            SPEED: begin
               speed_ff[cnt_ff] <= speed_in;
               state_ff         <= MUL;
            end
            MUL: begin
               state_ff <= POS;
            end
            POS: begin
               // hold until the output register can take the item
               if (rsp_free) begin
                  position_ff[cnt_ff] <= pos_in;
                  if (cnt_ff == LAST_COL) begin
                     state_ff <= IDLE;
                  end else begin
                     cnt_ff   <= cnt_ff + 1'b1;
                     state_ff <= SPEED;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == POS && rsp_free) begin
         rsp_column_ff   <= 3'(cnt_ff);
         rsp_position_ff <= pos_in;
         rsp_speed_ff    <= speed_ff[cnt_ff];
         rsp_last_ff     <= (cnt_ff == LAST_COL);
      end
   end

   assign req_stall      = (state_ff != IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_column     = rsp_column_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_speed      = rsp_speed_ff;
   assign rsp_cursor_row = ~rsp_position_ff[31:29];
   assign rsp_moving     = (rsp_speed_ff != '0);
   assign rsp_last       = rsp_last_ff;

endmodule
